// ===== rtl/core/string_key_sort_and_search_unit_macros.svh =====
// Assertion macros for the string key sort and search unit.
// Used by the datapath; no other dependencies.
`ifndef STRING_KEY_SORT_AND_SEARCH_UNIT_MACROS_SVH
`define STRING_KEY_SORT_AND_SEARCH_UNIT_MACROS_SVH
`ifndef SYNTH
`define SKS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sks assertion failed");
`define SKS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sks assertion failed");
`else
`define SKS_ASSERT(lbl, clk, rst_n, prop)
`define SKS_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/sks_pkg.sv =====
// Shared types and constants of the string key sort and search unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sks_pkg;
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_SORT   = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_SORTED    = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_PAD, S_LD_COMMIT, S_EM_FULL, S_SK_PAD, S_SR_INIT, S_SR_MID,
    S_SR_RD, S_SR_EV, S_SR_CHK, S_SR_CODE, S_SR_FOUND, S_SR_MISS, S_SRT_ROW,
    S_CMP_CHK, S_CMP_RD, S_CMP_EV, S_SW_RD, S_SW_W1, S_SW_W2, S_CS_RD,
    S_CS_W1, S_CS_W2, S_SRT_DONE
  } state_t;

  typedef enum logic [4:0] {
    ACT_NONE, ACT_LD_BYTE, ACT_LD_FULL, ACT_LD_PAD, ACT_LD_COMMIT, ACT_EM_FULL,
    ACT_SK_BYTE, ACT_SK_PAD, ACT_SR_INIT, ACT_SR_MID, ACT_SR_EV, ACT_SR_FOUND,
    ACT_SR_MISS, ACT_SRT_INIT, ACT_SRT_ROW, ACT_K_CLR, ACT_CMP_EV, ACT_SW_W1,
    ACT_SW_W2, ACT_CS_W1, ACT_CS_W2, ACT_SRT_DONE
  } act_t;

  typedef enum logic [1:0] {
    ROW_J,
    ROW_I,
    ROW_MID
  } row_sel_t;

  typedef struct packed {
    act_t     act;
    row_sel_t row_sel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic slot_free;
    logic lpad_end;
    logic spad_end;
    logic i_end;
    logic j_end;
    logic k_end;
    logic byte_ne;
    logic lo_le_hi;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/string_key_sort_and_search_unit.sv =====
// Top level of the string key sort and search unit.
// Depends on sks_pkg, sks_ctrl and sks_datapath.
//
// Input stream: each request carries op, key_byte, key_last (tlast) and
// record_code. Load and search key bytes take one cycle each while the unit
// is idle. After a load's last byte the rest of the key is padded and
// "stored" is returned, or "table full" if the table is full. A sort request
// runs a selection sort on the record table: about N*N/2 key compares, byte
// by byte, then a swap of the key bytes and code per row, one byte at a time
// through the single key RAM write port. A search runs a binary search, up
// to log2(N)+1 probes, each compared byte by byte. While a sort
// or search runs, in_tready is low. The finished result sits in an output
// register, so a new request is taken while it waits; a stalled receiver
// holds the next result inside the unit until the slot frees. Reset clears
// the record count and the key byte indexes; the tables need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module string_key_sort_and_search_unit #(
  parameter int MAX_RECORDS = 128,
  parameter int KEY_BYTES   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // op[1:0], key_byte[9:2], record_code[41:10]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata   // status[2:0], position[9:3], found_code[41:10]
);
  sks_pkg::cmd_t cmd;
  sks_pkg::sts_t sts;
  logic [sks_pkg::STATUS_W-1:0] status;
  logic [sks_pkg::POS_W-1:0]    position;
  logic [sks_pkg::CODE_W-1:0]   found_code;

  sks_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_op(in_tdata[1:0]), .in_last(in_tlast), .sts(sts), .cmd(cmd)
  );

  sks_datapath #(.MAX_RECORDS(MAX_RECORDS), .KEY_BYTES(KEY_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_byte(in_tdata[9:2]), .in_code(in_tdata[41:10]),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(status), .out_pos(position), .out_code(found_code)
  );

  assign out_tdata = {6'b0, found_code, position, status};
endmodule
`default_nettype wire

// ===== rtl/core/sks_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

// ===== rtl/core/sks_ctrl.sv =====
// Controller state machine of the string key sort and search unit.
// Depends on sks_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sks_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [sks_pkg::OP_W-1:0] in_op,
  input  wire logic                     in_last,
  input  wire sks_pkg::sts_t            sts,
  output sks_pkg::cmd_t                 cmd
);
  sks_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sks_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sks_pkg::S_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            sks_pkg::OP_LOAD: begin
              if (sts.full) begin
                if (in_last) state_nxt = sks_pkg::S_EM_FULL;
              end else if (in_last) begin
                state_nxt = sks_pkg::S_LD_PAD;
              end
            end
            sks_pkg::OP_SORT:   state_nxt = sks_pkg::S_SRT_ROW;
            sks_pkg::OP_SEARCH: if (in_last) state_nxt = sks_pkg::S_SK_PAD;
            default:            state_nxt = sks_pkg::S_IDLE;
          endcase
        end
      end
      sks_pkg::S_LD_PAD:    if (sts.lpad_end) state_nxt = sks_pkg::S_LD_COMMIT;
      sks_pkg::S_LD_COMMIT: if (sts.slot_free) state_nxt = sks_pkg::S_IDLE;
      sks_pkg::S_EM_FULL:   if (sts.slot_free) state_nxt = sks_pkg::S_IDLE;
      sks_pkg::S_SK_PAD:    if (sts.spad_end) state_nxt = sks_pkg::S_SR_INIT;
      sks_pkg::S_SR_INIT: begin
        state_nxt = sts.cnt_zero ? sks_pkg::S_SR_MISS : sks_pkg::S_SR_MID;
      end
      sks_pkg::S_SR_MID: state_nxt = sks_pkg::S_SR_RD;
      sks_pkg::S_SR_RD:  state_nxt = sks_pkg::S_SR_EV;
      sks_pkg::S_SR_EV: begin
        if (sts.byte_ne) state_nxt = sks_pkg::S_SR_CHK;
        else if (sts.k_end) state_nxt = sks_pkg::S_SR_CODE;
        else state_nxt = sks_pkg::S_SR_RD;
      end
      sks_pkg::S_SR_CHK: begin
        state_nxt = sts.lo_le_hi ? sks_pkg::S_SR_MID : sks_pkg::S_SR_MISS;
      end
      sks_pkg::S_SR_CODE:  state_nxt = sks_pkg::S_SR_FOUND;
      sks_pkg::S_SR_FOUND: if (sts.slot_free) state_nxt = sks_pkg::S_IDLE;
      sks_pkg::S_SR_MISS:  if (sts.slot_free) state_nxt = sks_pkg::S_IDLE;
      sks_pkg::S_SRT_ROW: begin
        state_nxt = sts.i_end ? sks_pkg::S_SRT_DONE : sks_pkg::S_CMP_CHK;
      end
      sks_pkg::S_CMP_CHK: begin
        state_nxt = sts.j_end ? sks_pkg::S_SW_RD : sks_pkg::S_CMP_RD;
      end
      sks_pkg::S_CMP_RD: state_nxt = sks_pkg::S_CMP_EV;
      sks_pkg::S_CMP_EV: begin
        if (sts.byte_ne || sts.k_end) state_nxt = sks_pkg::S_CMP_CHK;
        else state_nxt = sks_pkg::S_CMP_RD;
      end
      sks_pkg::S_SW_RD: state_nxt = sks_pkg::S_SW_W1;
      sks_pkg::S_SW_W1: state_nxt = sks_pkg::S_SW_W2;
      sks_pkg::S_SW_W2: state_nxt = sts.k_end ? sks_pkg::S_CS_RD : sks_pkg::S_SW_RD;
      sks_pkg::S_CS_RD: state_nxt = sks_pkg::S_CS_W1;
      sks_pkg::S_CS_W1: state_nxt = sks_pkg::S_CS_W2;
      sks_pkg::S_CS_W2: state_nxt = sks_pkg::S_SRT_ROW;
      sks_pkg::S_SRT_DONE: if (sts.slot_free) state_nxt = sks_pkg::S_IDLE;
      default: state_nxt = sks_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = (state_r == sks_pkg::S_IDLE);
    cmd.act     = sks_pkg::ACT_NONE;
    cmd.row_sel = sks_pkg::ROW_J;
    case (state_r)
      sks_pkg::S_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            sks_pkg::OP_LOAD: begin
              if (sts.full) begin
                if (in_last) cmd.act = sks_pkg::ACT_LD_FULL;
              end else begin
                cmd.act = sks_pkg::ACT_LD_BYTE;
              end
            end
            sks_pkg::OP_SORT:   cmd.act = sks_pkg::ACT_SRT_INIT;
            sks_pkg::OP_SEARCH: cmd.act = sks_pkg::ACT_SK_BYTE;
            default:            cmd.act = sks_pkg::ACT_NONE;
          endcase
        end
      end
      sks_pkg::S_LD_PAD:    if (!sts.lpad_end) cmd.act = sks_pkg::ACT_LD_PAD;
      sks_pkg::S_LD_COMMIT: if (sts.slot_free) cmd.act = sks_pkg::ACT_LD_COMMIT;
      sks_pkg::S_EM_FULL:   if (sts.slot_free) cmd.act = sks_pkg::ACT_EM_FULL;
      sks_pkg::S_SK_PAD:    if (!sts.spad_end) cmd.act = sks_pkg::ACT_SK_PAD;
      sks_pkg::S_SR_INIT:   cmd.act = sks_pkg::ACT_SR_INIT;
      sks_pkg::S_SR_MID: begin
        cmd.act     = sks_pkg::ACT_SR_MID;
        cmd.row_sel = sks_pkg::ROW_MID;
      end
      sks_pkg::S_SR_RD, sks_pkg::S_SR_CHK, sks_pkg::S_SR_CODE: begin
        cmd.row_sel = sks_pkg::ROW_MID;
      end
      sks_pkg::S_SR_EV: begin
        cmd.act     = sks_pkg::ACT_SR_EV;
        cmd.row_sel = sks_pkg::ROW_MID;
      end
      sks_pkg::S_SR_FOUND: begin
        cmd.row_sel = sks_pkg::ROW_MID;
        if (sts.slot_free) cmd.act = sks_pkg::ACT_SR_FOUND;
      end
      sks_pkg::S_SR_MISS: if (sts.slot_free) cmd.act = sks_pkg::ACT_SR_MISS;
      sks_pkg::S_SRT_ROW: if (!sts.i_end) cmd.act = sks_pkg::ACT_SRT_ROW;
      sks_pkg::S_CMP_CHK: cmd.act = sks_pkg::ACT_K_CLR;
      sks_pkg::S_CMP_EV:  cmd.act = sks_pkg::ACT_CMP_EV;
      sks_pkg::S_SW_RD, sks_pkg::S_CS_RD: cmd.row_sel = sks_pkg::ROW_I;
      sks_pkg::S_SW_W1: begin
        cmd.act     = sks_pkg::ACT_SW_W1;
        cmd.row_sel = sks_pkg::ROW_I;
      end
      sks_pkg::S_SW_W2: begin
        cmd.act     = sks_pkg::ACT_SW_W2;
        cmd.row_sel = sks_pkg::ROW_I;
      end
      sks_pkg::S_CS_W1: begin
        cmd.act     = sks_pkg::ACT_CS_W1;
        cmd.row_sel = sks_pkg::ROW_I;
      end
      sks_pkg::S_CS_W2: begin
        cmd.act     = sks_pkg::ACT_CS_W2;
        cmd.row_sel = sks_pkg::ROW_I;
      end
      sks_pkg::S_SRT_DONE: if (sts.slot_free) cmd.act = sks_pkg::ACT_SRT_DONE;
      default: cmd.act = sks_pkg::ACT_NONE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/sks_datapath.sv =====
// Datapath: key, code and search key RAMs, counters, byte compare, result register.
// Depends on sks_pkg, sks_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "string_key_sort_and_search_unit_macros.svh"
module sks_datapath #(
  parameter int MAX_RECORDS = 128,
  parameter int KEY_BYTES   = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire sks_pkg::cmd_t                  cmd,
  output sks_pkg::sts_t                       sts,
  input  wire logic [sks_pkg::BYTE_W-1:0]     in_byte,
  input  wire logic [sks_pkg::CODE_W-1:0]     in_code,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [sks_pkg::STATUS_W-1:0]   out_status,
  output logic      [sks_pkg::POS_W-1:0]      out_pos,
  output logic      [sks_pkg::CODE_W-1:0]     out_code
);
  localparam int CW  = $clog2(MAX_RECORDS + 1);
  localparam int RW  = $clog2(MAX_RECORDS);
  localparam int KBW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int IW  = $clog2(KEY_BYTES + 1);
  localparam int AW  = RW + KBW;
  localparam int BW  = sks_pkg::BYTE_W;
  localparam int DW  = sks_pkg::CODE_W;

  logic [CW-1:0]        count_r, i_r, j_r;
  logic [RW-1:0]        m_r, mid_r;
  logic [KBW-1:0]       k_r;
  logic [IW-1:0]        lidx_r, sidx_r;
  logic                 lzero_r, szero_r;
  logic signed [CW:0]   lo_r, hi_r;
  logic [BW-1:0]        tmp_r;
  logic [DW-1:0]        tmpc_r, code_r;
  logic                 out_valid_r;
  logic [sks_pkg::STATUS_W-1:0] out_status_r;
  logic [sks_pkg::POS_W-1:0]    out_pos_r;
  logic [DW-1:0]        out_code_r;

  logic [RW-1:0]  row_a;
  logic [AW-1:0]  kw_addr;
  logic [BW-1:0]  kw_data, key_a, key_b, sk_rd, cmp_b, lbyte, sbyte;
  logic           kw_en, cw_en, sw_en, emit, byte_lt;
  logic [RW-1:0]  cw_addr;
  logic [DW-1:0]  cw_data, code_a, code_b;
  logic [KBW-1:0] sw_addr;
  logic [CW:0]    mid_sum;

  always_comb begin
    case (cmd.row_sel)
      sks_pkg::ROW_I:   row_a = i_r[RW-1:0];
      sks_pkg::ROW_MID: row_a = mid_r;
      default:          row_a = j_r[RW-1:0];
    endcase
  end

  assign lbyte   = (lidx_r != '0 && lzero_r) ? '0 : in_byte;
  assign sbyte   = (sidx_r != '0 && szero_r) ? '0 : in_byte;
  assign cmp_b   = (cmd.row_sel == sks_pkg::ROW_MID) ? sk_rd : key_b;
  assign byte_lt = key_a < cmp_b;
  assign mid_sum = (CW+1)'(lo_r[CW-1:0]) + (CW+1)'(hi_r[CW-1:0]);

  always_comb begin
    kw_en   = 1'b0;
    kw_addr = {count_r[RW-1:0], lidx_r[KBW-1:0]};
    kw_data = '0;
    cw_en   = 1'b0;
    cw_addr = count_r[RW-1:0];
    cw_data = code_r;
    sw_en   = 1'b0;
    sw_addr = sidx_r[KBW-1:0];
    case (cmd.act)
      sks_pkg::ACT_LD_BYTE: begin
        kw_en   = !sts.lpad_end;
        kw_data = lbyte;
      end
      sks_pkg::ACT_LD_PAD:    kw_en = 1'b1;
      sks_pkg::ACT_LD_COMMIT: cw_en = 1'b1;
      sks_pkg::ACT_SK_BYTE:   sw_en = !sts.spad_end;
      sks_pkg::ACT_SK_PAD:    sw_en = 1'b1;
      sks_pkg::ACT_SW_W1: begin
        kw_en   = 1'b1;
        kw_addr = {i_r[RW-1:0], k_r};
        kw_data = key_b;
      end
      sks_pkg::ACT_SW_W2: begin
        kw_en   = 1'b1;
        kw_addr = {m_r, k_r};
        kw_data = tmp_r;
      end
      sks_pkg::ACT_CS_W1: begin
        cw_en   = 1'b1;
        cw_addr = i_r[RW-1:0];
        cw_data = code_b;
      end
      sks_pkg::ACT_CS_W2: begin
        cw_en   = 1'b1;
        cw_addr = m_r;
        cw_data = tmpc_r;
      end
      default: kw_en = 1'b0;
    endcase
  end

  sks_ram #(.WIDTH(BW), .DEPTH(MAX_RECORDS << KBW)) u_key_ram (
    .clk(clk), .we(kw_en), .waddr(kw_addr), .wdata(kw_data),
    .raddr_a({row_a, k_r}), .raddr_b({m_r, k_r}),
    .rdata_a(key_a), .rdata_b(key_b)
  );

  sks_ram #(.WIDTH(DW), .DEPTH(MAX_RECORDS)) u_code_ram (
    .clk(clk), .we(cw_en), .waddr(cw_addr), .wdata(cw_data),
    .raddr_a(row_a), .raddr_b(m_r),
    .rdata_a(code_a), .rdata_b(code_b)
  );

  sks_ram #(.WIDTH(BW), .DEPTH(1 << KBW)) u_skey_ram (
    .clk(clk), .we(sw_en), .waddr(sw_addr),
    .wdata((cmd.act == sks_pkg::ACT_SK_BYTE) ? sbyte : '0),
    .raddr_a(k_r), .raddr_b(k_r),
    .rdata_a(sk_rd), .rdata_b()
  );

  always_comb begin
    sts.full      = count_r >= CW'(MAX_RECORDS);
    sts.cnt_zero  = count_r == '0;
    sts.slot_free = !out_valid_r || out_ready;
    sts.lpad_end  = lidx_r >= IW'(KEY_BYTES);
    sts.spad_end  = sidx_r >= IW'(KEY_BYTES);
    sts.i_end     = i_r >= count_r;
    sts.j_end     = j_r >= count_r;
    sts.k_end     = k_r == KBW'(KEY_BYTES - 1);
    sts.byte_ne   = key_a != cmp_b;
    sts.lo_le_hi  = lo_r <= hi_r;
  end

  assign emit = (cmd.act == sks_pkg::ACT_LD_COMMIT) || (cmd.act == sks_pkg::ACT_EM_FULL) ||
                (cmd.act == sks_pkg::ACT_SRT_DONE) || (cmd.act == sks_pkg::ACT_SR_FOUND) ||
                (cmd.act == sks_pkg::ACT_SR_MISS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      lidx_r      <= '0;
      lzero_r     <= 1'b0;
      sidx_r      <= '0;
      szero_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (cmd.act)
        sks_pkg::ACT_LD_BYTE: begin
          code_r <= in_code;
          if (!sts.lpad_end) begin
            lidx_r  <= lidx_r + IW'(1);
            lzero_r <= lbyte == '0;
          end
        end
        sks_pkg::ACT_LD_PAD: lidx_r <= lidx_r + IW'(1);
        sks_pkg::ACT_LD_COMMIT: begin
          count_r <= count_r + CW'(1);
          lidx_r  <= '0;
          lzero_r <= 1'b0;
        end
        sks_pkg::ACT_LD_FULL: begin
          lidx_r  <= '0;
          lzero_r <= 1'b0;
        end
        sks_pkg::ACT_SK_BYTE: begin
          if (!sts.spad_end) begin
            sidx_r  <= sidx_r + IW'(1);
            szero_r <= sbyte == '0;
          end
        end
        sks_pkg::ACT_SK_PAD: sidx_r <= sidx_r + IW'(1);
        sks_pkg::ACT_SR_INIT: begin
          sidx_r  <= '0;
          szero_r <= 1'b0;
        end
        default: lzero_r <= lzero_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.act)
      sks_pkg::ACT_LD_COMMIT: begin
        out_status_r <= sks_pkg::ST_STORED;
        out_pos_r    <= '0;
        out_code_r   <= '0;
      end
      sks_pkg::ACT_EM_FULL: begin
        out_status_r <= sks_pkg::ST_FULL;
        out_pos_r    <= '0;
        out_code_r   <= '0;
      end
      sks_pkg::ACT_SRT_DONE: begin
        out_status_r <= sks_pkg::ST_SORTED;
        out_pos_r    <= '0;
        out_code_r   <= '0;
      end
      sks_pkg::ACT_SR_MISS: begin
        out_status_r <= sks_pkg::ST_NOT_FOUND;
        out_pos_r    <= '0;
        out_code_r   <= '0;
      end
      sks_pkg::ACT_SR_FOUND: begin
        out_status_r <= sks_pkg::ST_FOUND;
        out_pos_r    <= sks_pkg::POS_W'(mid_r);
        out_code_r   <= code_a;
      end
      sks_pkg::ACT_SR_INIT: begin
        lo_r <= '0;
        hi_r <= $signed({1'b0, count_r}) - $signed((CW+1)'(1));
      end
      sks_pkg::ACT_SR_MID: begin
        mid_r <= mid_sum[RW:1];
        k_r   <= '0;
      end
      sks_pkg::ACT_SR_EV: begin
        if (sts.byte_ne) begin
          if (byte_lt) lo_r <= $signed((CW+1)'(mid_r) + (CW+1)'(1));
          else hi_r <= $signed((CW+1)'(mid_r)) - $signed((CW+1)'(1));
        end else if (!sts.k_end) begin
          k_r <= k_r + KBW'(1);
        end
      end
      sks_pkg::ACT_SRT_INIT: i_r <= '0;
      sks_pkg::ACT_SRT_ROW: begin
        m_r <= i_r[RW-1:0];
        j_r <= i_r + CW'(1);
        k_r <= '0;
      end
      sks_pkg::ACT_K_CLR: k_r <= '0;
      sks_pkg::ACT_CMP_EV: begin
        if (sts.byte_ne) begin
          if (byte_lt) m_r <= j_r[RW-1:0];
          j_r <= j_r + CW'(1);
        end else if (sts.k_end) begin
          j_r <= j_r + CW'(1);
        end else begin
          k_r <= k_r + KBW'(1);
        end
      end
      sks_pkg::ACT_SW_W1: tmp_r <= key_a;
      sks_pkg::ACT_SW_W2: if (!sts.k_end) k_r <= k_r + KBW'(1);
      sks_pkg::ACT_CS_W1: tmpc_r <= code_a;
      sks_pkg::ACT_CS_W2: i_r <= i_r + CW'(1);
      default: tmp_r <= tmp_r;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_pos    = out_pos_r;
  assign out_code   = out_code_r;

  `SKS_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(MAX_RECORDS))
  `SKS_ASSERT(a_emit_slot, clk, rst_n, emit |-> (!out_valid_r || out_ready))
  `SKS_ASSERT(a_commit_inc, clk, rst_n, (cmd.act == sks_pkg::ACT_LD_COMMIT) |=> (count_r == $past(count_r) + CW'(1)))
  `SKS_ASSERT(a_min_not_below_row, clk, rst_n, (cmd.act == sks_pkg::ACT_CMP_EV) |-> (m_r >= i_r[RW-1:0]))
endmodule
`default_nettype wire
